// ----- hdl/rsd_pkg.sv -----
// shared types, constants and register map of the sprite rle row decoder
`default_nettype none

package rsd_pkg;

  localparam int MAX_DIM_DEF  = 1024;
  localparam int CFG_DIM_W    = 11;
  localparam int POS_W        = 10;
  localparam int BOX_W        = 11;
  localparam int BYTE_W       = 8;
  localparam int CNT_W        = 7;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 32;
  localparam int OUT_DATA_W   = 80;

  localparam logic [BYTE_W-1:0] COPY_MASK    = 8'h7f;
  localparam logic [BYTE_W-1:0] SHADOW_INDEX = 8'd47;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SHADOW_MODE  = 2'd2;

  typedef enum logic [2:0] {
    KIND_SKIP    = 3'd0,
    KIND_SHADOW  = 3'd1,
    KIND_LITERAL = 3'd2,
    KIND_DONE    = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE,
    ST_ERR
  } status_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] frame_width;
    logic [CFG_DIM_W-1:0] frame_height;
    logic                 shadow_mode;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  column;
    logic [BYTE_W-1:0] run_length;
    logic [BYTE_W-1:0] pixel_value;
    logic [POS_W-1:0]  box_left;
    logic [POS_W-1:0]  box_top;
    logic [BOX_W-1:0]  box_width;
    logic [BOX_W-1:0]  box_height;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/rsd_cfg_regs.sv -----
// apb configuration registers of the sprite rle row decoder
`default_nettype none

module rsd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rsd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [rsd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [rsd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready,
  output rsd_pkg::cfg_t                 cfg
);
  import rsd_pkg::*;

  logic [CFG_DIM_W-1:0] frame_width_r;
  logic [CFG_DIM_W-1:0] frame_height_r;
  logic                 shadow_mode_r;
  logic                 wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_DIM_W'(1);
      frame_height_r <= CFG_DIM_W'(1);
      shadow_mode_r  <= 1'b0;
    end else if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[CFG_DIM_W-1:0];
        REG_SHADOW_MODE:  shadow_mode_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_FRAME_WIDTH:  cfg_prdata = CFG_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = CFG_DATA_W'(frame_height_r);
      REG_SHADOW_MODE:  cfg_prdata = CFG_DATA_W'(shadow_mode_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign cfg.frame_width  = frame_width_r;
  assign cfg.frame_height = frame_height_r;
  assign cfg.shadow_mode  = shadow_mode_r;

endmodule

`default_nettype wire

// ----- hdl/rsd_decode.sv -----
// input register, decode state and single-pass decode of one code byte
`default_nettype none

module rsd_decode #(
  parameter int MAX_DIM = rsd_pkg::MAX_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rsd_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rsd_pkg::BYTE_W-1:0] in_byte,
  input  logic                      in_fstart,
  input  logic                      in_fend,
  input  logic                      buf_ready,
  output logic                      load,
  output rsd_pkg::res_t             res0,
  output rsd_pkg::res_t             res1,
  output logic [1:0]                res_cnt
);
  import rsd_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int SUM_W = ((DIM_W > BYTE_W) ? DIM_W : BYTE_W) + 1;
  localparam int EXT_W = (DIM_W > BOX_W) ? DIM_W : BOX_W;

  logic [BYTE_W-1:0] byte_r;
  logic              fstart_r;
  logic              fend_r;
  logic              valid_r;

  logic [DIM_W-1:0]  col_r, col_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic              phase_r, phase_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [DIM_W-1:0]  min_col_r, min_col_nxt;
  logic [DIM_W-1:0]  min_row_r, min_row_nxt;
  logic [DIM_W-1:0]  max_col_r, max_col_nxt;
  logic [DIM_W-1:0]  max_row_r, max_row_nxt;
  logic              seen_r, seen_nxt;
  status_t           status_r, status_nxt;

  logic [DIM_W-1:0]  w, h;
  logic [BYTE_W-1:0] count;
  logic [SUM_W-1:0]  sum;
  logic              stop;
  logic              mark_en;
  logic [DIM_W-1:0]  mark_c0, mark_c1, mark_r;
  logic [DIM_W-1:0]  bl, bt, bw, bh;
  logic [1:0]        n;
  res_t              res [2];

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    else if (32'(v) > MAX_DIM) return DIM_W'(MAX_DIM);
    else return DIM_W'(v);
  endfunction

  function automatic logic [POS_W-1:0] pos_f(input logic [DIM_W-1:0] v);
    logic [EXT_W-1:0] t;
    t = EXT_W'(v);
    return t[POS_W-1:0];
  endfunction

  function automatic logic [BOX_W-1:0] box_f(input logic [DIM_W-1:0] v);
    logic [EXT_W-1:0] t;
    t = EXT_W'(v);
    return t[BOX_W-1:0];
  endfunction

  function automatic res_t make_res(input kind_t k, input logic [DIM_W-1:0] r,
                                    input logic [DIM_W-1:0] c,
                                    input logic [BYTE_W-1:0] run,
                                    input logic [BYTE_W-1:0] val);
    res_t x;
    x             = '0;
    x.kind        = k;
    x.row         = pos_f(r);
    x.column      = pos_f(c);
    x.run_length  = run;
    x.pixel_value = val;
    return x;
  endfunction

  assign w        = eff_dim(cfg.frame_width);
  assign h        = eff_dim(cfg.frame_height);
  assign load     = valid_r && buf_ready;
  assign in_ready = !valid_r || buf_ready;

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    phase_nxt   = phase_r;
    left_nxt    = left_r;
    min_col_nxt = min_col_r;
    min_row_nxt = min_row_r;
    max_col_nxt = max_col_r;
    max_row_nxt = max_row_r;
    seen_nxt    = seen_r;
    status_nxt  = status_r;
    count       = '0;
    sum         = '0;
    stop        = 1'b0;
    mark_en     = 1'b0;
    mark_c0     = '0;
    mark_c1     = '0;
    mark_r      = '0;
    bl          = '0;
    bt          = '0;
    bw          = '0;
    bh          = '0;
    n           = 2'd0;
    res[0]      = '0;
    res[1]      = '0;

    if (fstart_r) begin
      col_nxt     = '0;
      row_nxt     = '0;
      phase_nxt   = 1'b0;
      left_nxt    = '0;
      min_col_nxt = w;
      min_row_nxt = h;
      max_col_nxt = '0;
      max_row_nxt = '0;
      seen_nxt    = 1'b0;
      status_nxt  = ST_RUN;
    end

    if (status_nxt == ST_RUN) begin
      if (left_nxt != '0) begin
        res[n[0]] = make_res(KIND_LITERAL, row_nxt, col_nxt, 8'd1, byte_r);
        n         = n + 2'd1;
        mark_en   = (byte_r != '0);
        mark_c0   = col_nxt;
        mark_c1   = col_nxt;
        mark_r    = row_nxt;
        col_nxt   = col_nxt + DIM_W'(1);
        left_nxt  = left_nxt - CNT_W'(1);
      end else begin
        count = phase_nxt ? (byte_r & COPY_MASK) : byte_r;
        sum   = SUM_W'(col_nxt) + SUM_W'(count);
        if (sum > SUM_W'(w)) begin
          res[n[0]]  = make_res(KIND_ERROR, row_nxt, col_nxt, '0, '0);
          n          = n + 2'd1;
          status_nxt = ST_ERR;
          stop       = 1'b1;
        end else begin
          if (!phase_nxt) begin
            if (count != '0) begin
              res[n[0]] = make_res(KIND_SKIP, row_nxt, col_nxt, count, '0);
              n         = n + 2'd1;
            end
            col_nxt = DIM_W'(sum);
          end else if (cfg.shadow_mode) begin
            if (count != '0) begin
              res[n[0]] = make_res(KIND_SHADOW, row_nxt, col_nxt, count, SHADOW_INDEX);
              n         = n + 2'd1;
              mark_en   = 1'b1;
              mark_c0   = col_nxt;
              mark_c1   = DIM_W'(sum - SUM_W'(1));
              mark_r    = row_nxt;
            end
            col_nxt = DIM_W'(sum);
          end else begin
            left_nxt = count[CNT_W-1:0];
          end
          phase_nxt = !phase_nxt;
        end
      end

      if (mark_en) begin
        if (mark_c0 < min_col_nxt) min_col_nxt = mark_c0;
        if (mark_r < min_row_nxt) min_row_nxt = mark_r;
        if (!seen_nxt || mark_c1 > max_col_nxt) max_col_nxt = mark_c1;
        if (!seen_nxt || mark_r > max_row_nxt) max_row_nxt = mark_r;
        seen_nxt = 1'b1;
      end

      if (!stop) begin
        if (left_nxt == '0 && col_nxt >= w) begin
          col_nxt   = '0;
          phase_nxt = 1'b0;
          row_nxt   = row_nxt + DIM_W'(1);
          if (row_nxt >= h) begin
            if (seen_nxt) begin
              bl = min_col_nxt;
              bt = min_row_nxt;
              bw = max_col_nxt - min_col_nxt + DIM_W'(1);
              bh = max_row_nxt - min_row_nxt + DIM_W'(1);
            end else begin
              bw = w;
              bh = h;
            end
            res[n[0]]            = make_res(KIND_DONE, row_nxt, col_nxt, '0, '0);
            res[n[0]].box_left   = pos_f(bl);
            res[n[0]].box_top    = pos_f(bt);
            res[n[0]].box_width  = box_f(bw);
            res[n[0]].box_height = box_f(bh);
            n                    = n + 2'd1;
            status_nxt           = ST_DONE;
          end
        end
        if (fend_r && status_nxt == ST_RUN) begin
          res[n[0]]  = make_res(KIND_ERROR, row_nxt, col_nxt, '0, '0);
          n          = n + 2'd1;
          status_nxt = ST_ERR;
        end
      end
    end

    if (n != 2'd0) res[1'(n - 2'd1)].last = 1'b1;
  end

  assign res0    = res[0];
  assign res1    = res[1];
  assign res_cnt = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
      phase_r   <= 1'b0;
      left_r    <= '0;
      min_col_r <= DIM_W'(1);
      min_row_r <= DIM_W'(1);
      max_col_r <= '0;
      max_row_r <= '0;
      seen_r    <= 1'b0;
      status_r  <= ST_IDLE;
    end else begin
      if (in_valid && in_ready) begin
        valid_r  <= 1'b1;
        byte_r   <= in_byte;
        fstart_r <= in_fstart;
        fend_r   <= in_fend;
      end else if (load) begin
        valid_r <= 1'b0;
      end
      if (load) begin
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        phase_r   <= phase_nxt;
        left_r    <= left_nxt;
        min_col_r <= min_col_nxt;
        min_row_r <= min_row_nxt;
        max_col_r <= max_col_nxt;
        max_row_r <= max_row_nxt;
        seen_r    <= seen_nxt;
        status_r  <= status_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rsd_out_buf.sv -----
// two-entry result register between decode and the result channel
`default_nettype none

module rsd_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  rsd_pkg::res_t res0,
  input  rsd_pkg::res_t res1,
  input  logic [1:0]    res_cnt,
  output logic          buf_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rsd_pkg::res_t out_res
);
  import rsd_pkg::*;

  logic [1:0] cnt_r;
  res_t       slot0_r;
  res_t       slot1_r;
  logic       fire;

  assign out_valid = (cnt_r != 2'd0);
  assign fire      = out_valid && out_ready;
  assign buf_ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign out_res   = slot0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r   <= res_cnt;
      slot0_r <= res0;
      slot1_r <= res1;
    end else if (fire) begin
      cnt_r   <= cnt_r - 2'd1;
      slot0_r <= slot1_r;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sprite_rle_row_decoder.sv -----
// the first result of a byte is offered from the result buffer, after the byte has passed the input register
// throughput: one code byte per cycle while each byte gives at most one result and out_tready is high
// a byte with two results holds the input side until its first result has left the result buffer
// reset: synchronous active-low rst_n clears the decode state to idle and the
// registers to width 1, height 1, shadow mode off
`default_nettype none

module sprite_rle_row_decoder #(
  parameter int MAX_DIM = rsd_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // code_byte
  input  logic                              in_tuser,   // frame_start
  input  logic                              in_tlast,   // final_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // row, column, run_length, pixel_value, box_left, box_top, box_width, box_height
  output logic [rsd_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [2:0]                        out_tuser,  // kind
  output logic                              out_tlast,  // last
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [rsd_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [rsd_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [rsd_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import rsd_pkg::*;

  cfg_t       cfg;
  logic       buf_ready;
  logic       load;
  res_t       res0, res1, out_res;
  logic [1:0] res_cnt;

  rsd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  rsd_decode #(.MAX_DIM(MAX_DIM)) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_fstart (in_tuser),
    .in_fend   (in_tlast),
    .buf_ready (buf_ready),
    .load      (load),
    .res0      (res0),
    .res1      (res1),
    .res_cnt   (res_cnt)
  );

  rsd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res0      (res0),
    .res1      (res1),
    .res_cnt   (res_cnt),
    .buf_ready (buf_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {2'b00, out_res.box_height, out_res.box_width, out_res.box_top,
                      out_res.box_left, out_res.pixel_value, out_res.run_length,
                      out_res.column, out_res.row};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

`default_nettype wire

// ----- hdl/rsd_checker.sv -----
// port-level checks of the sprite rle row decoder and their bind
`default_nettype none

module rsd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [rsd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [2:0]                     out_tuser,
  input logic                           out_tlast,
  input logic                           cfg_psel,
  input logic                           cfg_penable,
  input logic                           cfg_pwrite,
  input logic [rsd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input logic [rsd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input logic [rsd_pkg::CFG_DATA_W-1:0] cfg_prdata
);
  import rsd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result changed");

  // frame done and error end the results of their byte
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_DONE || out_tuser == KIND_ERROR) |-> out_tlast)
    else $error("done or error result without last");

  // box fields only on frame done
  a_box_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_DONE |-> out_tdata[77:36] == '0)
    else $error("box fields set outside frame done");

  // literal pixel has run length one
  a_lit_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_LITERAL |-> out_tdata[27:20] == 8'd1)
    else $error("literal pixel run length not one");

  // width register reads back what was written
  a_cfg_rb: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 4'd0)
      ##1 (cfg_psel && !cfg_pwrite && cfg_paddr == 4'd0)
      |-> cfg_prdata[10:0] == $past(cfg_pwdata[10:0]))
    else $error("frame width readback mismatch");

endmodule

bind sprite_rle_row_decoder rsd_checker u_rsd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .out_tuser   (out_tuser),
  .out_tlast   (out_tlast),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata)
);

`default_nettype wire
